@@ design/rbdq_pkg.sv @@
// ----------------------------------------------------------------------------
// rbdq_pkg
// shared types and constants for the ring buffer deque
// ----------------------------------------------------------------------------
package rbdq_pkg;

    localparam int WORD_W    = 32;
    localparam int DEPTH_DEF = 16;
    localparam int FUNC_W    = 2;
    localparam int STATUS_W  = 2;

    typedef enum logic [FUNC_W-1:0] {
        OP_PUSH_FRONT = 2'd0,
        OP_PUSH_REAR  = 2'd1,
        OP_POP_FRONT  = 2'd2,
        OP_POP_REAR   = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // per-transaction result info handed from control to the result stage
    typedef struct packed {
        t_status status;
        logic    pop_ok;
        logic    now_empty;
        logic    now_full;
    } t_step_info;

endpackage

@@ design/rbdq_ram.sv @@
// ----------------------------------------------------------------------------
// rbdq_ram
// generic simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module rbdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/rbdq_ctrl.sv @@
// ----------------------------------------------------------------------------
// rbdq_ctrl
// head/tail pointers, empty flag and ram access decode for one operation
// ----------------------------------------------------------------------------
module rbdq_ctrl
    import rbdq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_accept,
    input  logic [FUNC_W-1:0]        i_func,
    input  logic [WORD_W-1:0]        i_value,
    output logic                     o_we,
    output logic [$clog2(DEPTH)-1:0] o_waddr,
    output logic [WORD_W-1:0]        o_wdata,
    output logic                     o_re,
    output logic [$clog2(DEPTH)-1:0] o_raddr,
    output t_step_info               o_info
);

    localparam int AW = $clog2(DEPTH);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    logic [AW-1:0] r_head, n_head;
    logic [AW-1:0] r_tail, n_tail;
    logic          r_empty, n_empty;
    logic          full_now;

    function automatic logic [AW-1:0] nxt(input logic [AW-1:0] p);
        return (p == LAST) ? '0 : p + AW'(1);
    endfunction

    function automatic logic [AW-1:0] prv(input logic [AW-1:0] p);
        return (p == '0) ? LAST : p - AW'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_empty <= 1'b1;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_empty <= n_empty;
        end
    end

    assign full_now = !r_empty && (r_head == nxt(r_tail));
    assign o_wdata  = i_value;

    always_comb begin
        n_head         = r_head;
        n_tail         = r_tail;
        n_empty        = r_empty;
        o_we           = 1'b0;
        o_waddr        = '0;
        o_re           = 1'b0;
        o_raddr        = r_head;
        o_info.status  = ST_DONE;
        o_info.pop_ok  = 1'b0;
        if (i_accept) begin
            case (t_op'(i_func))
                OP_PUSH_FRONT, OP_PUSH_REAR: begin
                    if (full_now) begin
                        o_info.status = ST_FULL;
                    end else if (r_empty) begin
                        // first word always lands in slot zero
                        n_head  = '0;
                        n_tail  = '0;
                        n_empty = 1'b0;
                        o_we    = 1'b1;
                        o_waddr = '0;
                    end else if (t_op'(i_func) == OP_PUSH_FRONT) begin
                        n_head  = prv(r_head);
                        o_we    = 1'b1;
                        o_waddr = prv(r_head);
                    end else begin
                        n_tail  = nxt(r_tail);
                        o_we    = 1'b1;
                        o_waddr = nxt(r_tail);
                    end
                end
                OP_POP_FRONT, OP_POP_REAR: begin
                    if (r_empty) begin
                        o_info.status = ST_EMPTY;
                    end else begin
                        o_info.pop_ok = 1'b1;
                        o_re          = 1'b1;
                        o_raddr       = (t_op'(i_func) == OP_POP_FRONT) ? r_head : r_tail;
                        if (r_head == r_tail) begin
                            n_empty = 1'b1;
                            n_head  = '0;
                            n_tail  = '0;
                        end else if (t_op'(i_func) == OP_POP_FRONT) begin
                            n_head = nxt(r_head);
                        end else begin
                            n_tail = prv(r_tail);
                        end
                    end
                end
                default: begin
                    o_info.status = ST_DONE;
                end
            endcase
        end
        o_info.now_empty = n_empty;
        o_info.now_full  = !n_empty && (n_head == nxt(n_tail));
    end

endmodule

@@ design/ring_buffer_deque_top.sv @@
// ----------------------------------------------------------------------------
// ring_buffer_deque_top
// double-ended queue of signed 32-bit words kept in a ring ram
// ----------------------------------------------------------------------------
//  channel   direction  tdata                   tuser
//  s_axis    in         [31:0] value            [1:0] func
//  m_axis    out        [31:0] popped_value     [1:0] status, [2] now_empty,
//                                               [3] now_full
//
//  one transaction per cycle sustained while the output is not stalled; a
//  result passes the pending stage (ram read), then the output register
//  pointers update on acceptance, so a pop right after a push reads the
//  word written the cycle before through the ram
//  synchronous active-low reset clears pointers, empty flag and valids;
//  the ram is not cleared, its slots are only read after a push wrote them
//  a stalled output holds the result; one pending stage absorbs the ram
//  read so input keeps flowing until both stages are occupied
// ----------------------------------------------------------------------------
module ring_buffer_deque_top
    import rbdq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [WORD_W-1:0]   s_axis_tdata,   // [31:0] value
    input  logic [FUNC_W-1:0]   s_axis_tuser,   // [1:0] func
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [WORD_W-1:0]   m_axis_tdata,   // [31:0] popped_value
    output logic [3:0]          m_axis_tuser    // [1:0] status, [2] now_empty, [3] now_full
);

    localparam int AW = $clog2(DEPTH);

    logic              accept;
    logic              ram_we, ram_re;
    logic [AW-1:0]     ram_waddr, ram_raddr;
    logic [WORD_W-1:0] ram_wdata, ram_rdata;
    t_step_info        step_info;

    // pending stage: waits for the ram read data
    logic              r_p_valid;
    logic              r_p_fresh;    // ram output still holds this entry's word
    t_step_info        r_p_info;
    logic [WORD_W-1:0] r_p_word;
    logic [WORD_W-1:0] p_word;
    logic              p_move;

    // output register
    logic              r_o_valid;
    logic [WORD_W-1:0] r_o_data;
    logic [3:0]        r_o_user;

    assign p_move        = r_p_valid && (!r_o_valid || m_axis_tready);
    assign s_axis_tready = !r_p_valid || p_move;
    assign accept        = s_axis_tvalid && s_axis_tready;

    rbdq_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_func   (s_axis_tuser),
        .i_value  (s_axis_tdata),
        .o_we     (ram_we),
        .o_waddr  (ram_waddr),
        .o_wdata  (ram_wdata),
        .o_re     (ram_re),
        .o_raddr  (ram_raddr),
        .o_info   (step_info)
    );

    rbdq_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // refused pops and all pushes report zero
    assign p_word = !r_p_info.pop_ok ? '0 : (r_p_fresh ? ram_rdata : r_p_word);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
            r_p_fresh <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_p_valid <= 1'b1;
                r_p_fresh <= 1'b1;
            end else if (p_move) begin
                r_p_valid <= 1'b0;
                r_p_fresh <= 1'b0;
            end else begin
                // holding: ram output may change, keep the captured word
                r_p_fresh <= 1'b0;
            end
            if (p_move) begin
                r_o_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_p_info <= step_info;
        end
        r_p_word <= p_word;
        if (p_move) begin
            r_o_data <= p_word;
            r_o_user <= {r_p_info.now_full, r_p_info.now_empty, r_p_info.status};
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = r_o_data;
    assign m_axis_tuser  = r_o_user;

endmodule

@@ verif/tb_ring_buffer_deque_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ring_buffer_deque_top
// self-checking bench for the ring buffer deque: a mirror of the deque
// predicts every result, directed cases hit empty, full and extreme words,
// then biased random push/pop traffic runs under three idling mixes
// ----------------------------------------------------------------------------
module tb_ring_buffer_deque_top;
    import rbdq_pkg::*;

    localparam int DEPTH       = DEPTH_DEF;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_WAIT  = 8;
    localparam int MAX_REPORTS = 30;

    // one expected result, with the same fields as m_axis
    typedef struct packed {
        logic [WORD_W-1:0] popped;
        t_status           status;
        logic              now_empty;
        logic              now_full;
    } t_deque_result;

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [WORD_W-1:0]   s_axis_tdata  = '0;   // [31:0] value
    logic [FUNC_W-1:0]   s_axis_tuser  = '0;   // [1:0] func
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [WORD_W-1:0]   m_axis_tdata;         // [31:0] popped_value
    logic [3:0]          m_axis_tuser;         // [1:0] status, [2] now_empty, [3] now_full

    // mirror of the deque state
    logic [WORD_W-1:0]   slot_mirror [DEPTH];
    int unsigned         head_ptr    = 0;
    int unsigned         tail_ptr    = 0;
    logic                deque_empty = 1'b1;

    t_deque_result       expected_results [$];

    int src_idle_pct  = 14;
    int snk_idle_pct  = 66;
    int mismatches    = 0;
    int n_checked     = 0;
    int n_push_refused = 0;
    int n_pop_refused  = 0;
    int n_at_full      = 0;
    int stall_cycles   = 0;

    ring_buffer_deque_top #(
        .DEPTH (DEPTH)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // 100 MHz clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------------
    // deque mirror
    // ------------------------------------------------------------------------

    // full when not empty and the slot after the tail is the head
    function automatic logic deque_full();
        return !deque_empty && (head_ptr == (tail_ptr + 1) % DEPTH);
    endfunction

    // apply one operation to the mirror and return the result it produces
    function automatic t_deque_result deque_step(input t_op op, input logic [WORD_W-1:0] word);
        t_deque_result res;
        res = '{popped: '0, status: ST_DONE, now_empty: 1'b0, now_full: 1'b0};
        if (op == OP_PUSH_FRONT || op == OP_PUSH_REAR) begin
            if (deque_full()) begin
                res.status = ST_FULL;
            end else if (deque_empty) begin
                // first word always lands in slot zero
                head_ptr       = 0;
                tail_ptr       = 0;
                slot_mirror[0] = word;
                deque_empty    = 1'b0;
            end else if (op == OP_PUSH_FRONT) begin
                head_ptr              = (head_ptr + DEPTH - 1) % DEPTH;
                slot_mirror[head_ptr] = word;
            end else begin
                tail_ptr              = (tail_ptr + 1) % DEPTH;
                slot_mirror[tail_ptr] = word;
            end
        end else begin
            if (deque_empty) begin
                res.status = ST_EMPTY;
            end else begin
                res.popped = (op == OP_POP_FRONT) ? slot_mirror[head_ptr]
                                                  : slot_mirror[tail_ptr];
                if (head_ptr == tail_ptr) begin
                    // last word gone, pointers go home
                    deque_empty = 1'b1;
                    head_ptr    = 0;
                    tail_ptr    = 0;
                end else if (op == OP_POP_FRONT) begin
                    head_ptr = (head_ptr + 1) % DEPTH;
                end else begin
                    tail_ptr = (tail_ptr + DEPTH - 1) % DEPTH;
                end
            end
        end
        res.now_empty = deque_empty;
        res.now_full  = deque_full();
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------------

    // offer one transaction with a random lead-in gap, predict it on acceptance
    task automatic send_item(input t_op op, input logic [WORD_W-1:0] word);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        s_axis_tuser  <= op;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        expected_results.push_back(deque_step(op, word));
    endtask

    // hold the input until every predicted result has come back
    task automatic wait_for_drain();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (expected_results.size() != 0);
    endtask

    // ------------------------------------------------------------------------
    // output side
    // ------------------------------------------------------------------------

    // receiver backpressure
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
    end

    task automatic report_field(input string name, input logic [WORD_W-1:0] exp_val,
                                input logic [WORD_W-1:0] act_val);
        if (act_val !== exp_val) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %h, actual %h",
                         $time, name, exp_val, act_val);
        end
    endtask

    // compare every result transaction with the oldest prediction
    always @(posedge i_clk) begin
        t_deque_result exp_res;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: unexpected result, expected none, actual tdata %h tuser %h",
                             $time, m_axis_tdata, m_axis_tuser);
            end else begin
                exp_res = expected_results.pop_front();
                report_field("popped_value", exp_res.popped, m_axis_tdata);
                report_field("status", WORD_W'(exp_res.status), WORD_W'(m_axis_tuser[1:0]));
                report_field("now_empty", WORD_W'(exp_res.now_empty), WORD_W'(m_axis_tuser[2]));
                report_field("now_full", WORD_W'(exp_res.now_full), WORD_W'(m_axis_tuser[3]));
                n_checked++;
                if (exp_res.status == ST_FULL)  n_push_refused++;
                if (exp_res.status == ST_EMPTY) n_pop_refused++;
                if (exp_res.now_full)           n_at_full++;
            end
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // pops on a freshly reset deque must be refused from both ends
    task automatic test_empty_pops();
        send_item(OP_POP_FRONT, 32'h0000_0000);
        send_item(OP_POP_REAR, 32'hFFFF_FFFF);
        wait_for_drain();
    endtask

    // extreme words through both ends, ending with a pop of the last word
    task automatic test_extreme_words();
        send_item(OP_PUSH_FRONT, 32'h7FFF_FFFF);
        send_item(OP_PUSH_REAR, 32'h8000_0000);
        send_item(OP_PUSH_FRONT, 32'h0000_0000);
        send_item(OP_POP_REAR, 32'h0000_0000);
        send_item(OP_POP_FRONT, 32'h0000_0000);
        send_item(OP_POP_FRONT, 32'hFFFF_FFFF);
        wait_for_drain();
    endtask

    // fill from both ends until full, then push into a full deque
    task automatic test_fill_and_overflow();
        for (int k = 0; k < DEPTH; k++)
            send_item((k % 2) ? OP_PUSH_REAR : OP_PUSH_FRONT, 32'hA5A5_0000 + k);
        send_item(OP_PUSH_FRONT, 32'hFFFF_FFFF);
        send_item(OP_PUSH_REAR, 32'h8000_0000);
        wait_for_drain();
    endtask

    // random traffic in bursts whose push share swings the fill level
    // between empty and full
    task automatic test_random_traffic(input int n_items, input int src_pct, input int snk_pct);
        int          push_pct;
        t_op         op;
        logic [31:0] word;
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        push_pct     = 50;
        for (int k = 0; k < n_items; k++) begin
            if (k % 32 == 0) begin
                case ($urandom_range(2))
                    0:       push_pct = 15;
                    1:       push_pct = 50;
                    default: push_pct = 85;
                endcase
            end
            // pause mid phase until the output side catches up
            if (k == n_items / 2)
                wait_for_drain();
            if ($urandom_range(99) < push_pct)
                op = $urandom_range(1) ? OP_PUSH_REAR : OP_PUSH_FRONT;
            else
                op = $urandom_range(1) ? OP_POP_REAR : OP_POP_FRONT;
            case ($urandom_range(7))
                0:       word = 32'h8000_0000;
                1:       word = 32'h7FFF_FFFF;
                2:       word = $urandom_range(1) ? 32'h0000_0000 : 32'hFFFF_FFFF;
                default: word = $urandom;
            endcase
            send_item(op, word);
        end
        wait_for_drain();
    endtask

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------
    initial begin
        for (int k = 0; k < DEPTH; k++)
            slot_mirror[k] = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_pops();
        test_extreme_words();
        test_fill_and_overflow();
        test_random_traffic(424, 14, 66);
        test_random_traffic(424, 66, 14);
        test_random_traffic(424, 0, 0);

        // let any stray result show up before the verdict
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("checked %0d results: %0d refused pushes, %0d refused pops, %0d at full",
                 n_checked, n_push_refused, n_pop_refused, n_at_full);
        $display("idling mixes: light input with heavy output stall, the reverse, and none");
        if (mismatches == 0 && expected_results.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

@@ sim.f @@
design/rbdq_pkg.sv
design/rbdq_ram.sv
design/rbdq_ctrl.sv
design/ring_buffer_deque_top.sv
verif/tb_ring_buffer_deque_top.sv
